// ===== rtl/qat_pkg.sv =====
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants shared by the quoted argument tokenizer files.
// ----------------------------------------------------------------------------
package qat_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // final status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_CAPACITY = 2'd2,
    ST_PARSE    = 2'd3
  } status_t;

  // scanner modes
  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic       last;
    kind_t      kind;
    status_t    status;
    logic [7:0] value_byte;
    logic [5:0] char_pos;
    logic [4:0] arg_index;
  } res_t;

  localparam int unsigned MAX_RES = 3;  // results one byte can cause
  localparam int unsigned QDEPTH  = 4;  // result queue entries

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

endpackage

// ===== rtl/qat_outq.sv =====
// ----------------------------------------------------------------------------
// qat_outq
// Four-entry result queue; takes up to three results at once, drains one
// word per cycle toward the output stream while m_tready is high.
// ----------------------------------------------------------------------------
module qat_outq import qat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [1:0] load_cnt,
  input  res_t       load_res [MAX_RES],
  output logic       room,
  output logic       m_tvalid,
  input  logic       m_tready,
  output res_t       m_res
);

  localparam int unsigned CNTW = $clog2(QDEPTH + 1);

  res_t            ent      [QDEPTH];
  res_t            ent_next [QDEPTH];
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;
  logic [CNTW-1:0] base;
  logic [CNTW-1:0] off;
  logic            take;

  assign m_tvalid = (count != '0);
  assign m_res    = ent[0];
  assign take     = m_tvalid && m_tready;
  // room for a worst-case byte even if nothing drains
  assign room     = (count <= CNTW'(QDEPTH - MAX_RES));
  assign base     = count - CNTW'(take);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (take && (i + 1 < QDEPTH)) begin
        ent_next[i] = ent[i + 1];
      end else begin
        ent_next[i] = ent[i];
      end
      off = CNTW'(i) - base;
      if (load && (CNTW'(i) >= base) && (off < CNTW'(load_cnt))) begin
        ent_next[i] = load_res[off[1:0]];
      end
    end
    off        = '0;
    count_next = base + (load ? CNTW'(load_cnt) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      ent[i] <= ent_next[i];
    end
  end

endmodule

// ===== rtl/quoted_argument_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits command text into arguments with quoting and backslash escapes,
// emitting argument bytes, end marks and a final status per text.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                         | tuser | tlast
//  s_      | in  | [7:0] text_byte                               | -     | -
//  m_      | out | arg_index, char_pos, value_byte, status (24b) | kind  | last_of_run
//
// a byte is decoded in the cycle it is accepted and its results land in a
// four-entry output queue; one text byte per cycle when output flows.
// a zero byte can make three words, so input pauses until the queue
// holds at most one word; output drains one word per cycle while m_tready is high.
// synchronous reset clears the scanner state and empties the queue.
module quoted_argument_tokenizer import qat_pkg::*; #(
  parameter int unsigned MAX_ARGUMENTS     = 16,
  parameter int unsigned ARGUMENT_CAPACITY = 64,
  parameter int unsigned SOURCE_CAPACITY   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] arg_index, [10:5] char_pos,
                                 // [18:11] value_byte, [20:19] status, zero fill
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_of_run
);

  localparam int unsigned CW = $clog2(MAX_ARGUMENTS + 1);
  localparam int unsigned LW = $clog2(ARGUMENT_CAPACITY);
  localparam int unsigned TW = $clog2(SOURCE_CAPACITY + 1);

  mode_t          mode, mode_next;
  logic           qs, qs_next;
  logic           esc, esc_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [LW-1:0]  len, len_next;
  logic [TW-1:0]  txt, txt_next;
  logic           err, err_next;

  logic           accept;
  logic           room;
  res_t           res [MAX_RES];
  logic [1:0]     res_cnt;
  logic [1:0]     k;
  logic           lit_try, lit_fit, err1, do_end;
  logic [LW:0]    len_inc;
  logic [LW-1:0]  len1;
  logic [CW-1:0]  cnt1;
  status_t        st;
  logic           want_emit, want_end;
  logic [LW-1:0]  emit_len;
  logic [7:0]     b;
  logic [7:0]     q;
  res_t           m_res;

  function automatic logic [4:0] idx5(input logic [CW-1:0] v);
    logic [CW+4:0] w;
    w = {5'b0, v};
    return w[4:0];
  endfunction

  function automatic logic [5:0] pos6(input logic [LW-1:0] v);
    logic [LW+5:0] w;
    w = {6'b0, v};
    return w[5:0];
  endfunction

  // no input taken while reset is held
  assign s_tready = room && !rst;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign q        = qs ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mode_next = mode;
    qs_next   = qs;
    esc_next  = esc;
    cnt_next  = cnt;
    len_next  = len;
    txt_next  = txt;
    err_next  = err;
    res_cnt   = '0;
    k         = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    lit_try   = 1'b0;
    lit_fit   = 1'b0;
    err1      = err;
    do_end    = 1'b0;
    len_inc   = '0;
    len1      = len;
    cnt1      = cnt;
    st        = ST_OK;
    want_emit = 1'b0;
    want_end  = 1'b0;
    emit_len  = len;

    if (b == CH_NUL) begin
      // pending backslash is literal, then close a plain argument
      lit_try = !err && (mode != MODE_BETWEEN) && esc;
      len_inc = {1'b0, len} + 1'b1;
      lit_fit = len_inc < (LW + 1)'(ARGUMENT_CAPACITY);
      if (lit_try && lit_fit) begin
        res[k] = '{last: 1'b0, kind: KIND_BYTE, status: ST_OK, value_byte: CH_BSLASH,
                   char_pos: pos6(len), arg_index: idx5(cnt)};
        k    = k + 1'b1;
        len1 = len_inc[LW-1:0];
      end
      err1   = err | (lit_try & !lit_fit);
      do_end = !err1 && (mode == MODE_PLAIN);
      if (do_end) begin
        res[k] = '{last: 1'b0, kind: KIND_END, status: ST_OK, value_byte: 8'd0,
                   char_pos: pos6(len1), arg_index: idx5(cnt)};
        k = k + 1'b1;
      end
      cnt1 = cnt + CW'(do_end);
      if (txt == '0) begin
        st = ST_EMPTY;
      end else if (err1) begin
        st = ST_CAPACITY;
      end else if (mode == MODE_QUOTED) begin
        st = ST_PARSE;
      end else if (cnt1 == '0) begin
        st = ST_PARSE;
      end else begin
        st = ST_OK;
      end
      res[k] = '{last: 1'b1, kind: KIND_STATUS, status: st, value_byte: 8'd0,
                 char_pos: 6'd0, arg_index: idx5(cnt1)};
      res_cnt   = k + 1'b1;
      mode_next = MODE_BETWEEN;
      qs_next   = 1'b0;
      esc_next  = 1'b0;
      cnt_next  = '0;
      len_next  = '0;
      txt_next  = '0;
      err_next  = 1'b0;
    end else begin
      if (txt < TW'(SOURCE_CAPACITY)) begin
        txt_next = txt + 1'b1;
      end
      err_next = err | (txt_next >= TW'(SOURCE_CAPACITY));
      if (!err_next) begin
        case (mode)
          MODE_BETWEEN: begin
            if (!is_space(b)) begin
              if (cnt >= CW'(MAX_ARGUMENTS)) begin
                err_next = 1'b1;
              end else begin
                len_next = '0;
                esc_next = 1'b0;
                emit_len = '0;
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                  mode_next = MODE_QUOTED;
                  qs_next   = (b == CH_SQUOTE);
                end else begin
                  mode_next = MODE_PLAIN;
                  if (b == CH_BSLASH) begin
                    esc_next = 1'b1;
                  end else begin
                    want_emit = 1'b1;
                  end
                end
              end
            end
          end
          MODE_PLAIN: begin
            if (esc) begin
              esc_next  = 1'b0;
              want_emit = 1'b1;
            end else if (b == CH_BSLASH) begin
              esc_next = 1'b1;
            end else if (is_space(b)) begin
              want_end = 1'b1;
            end else begin
              want_emit = 1'b1;
            end
          end
          MODE_QUOTED: begin
            if (esc) begin
              esc_next  = 1'b0;
              want_emit = 1'b1;
            end else if (b == q) begin
              want_end = 1'b1;
            end else if (b == CH_BSLASH) begin
              esc_next = 1'b1;
            end else begin
              want_emit = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      len_inc = {1'b0, emit_len} + 1'b1;
      if (want_emit) begin
        if (len_inc >= (LW + 1)'(ARGUMENT_CAPACITY)) begin
          err_next = 1'b1;
        end else begin
          res[0] = '{last: 1'b1, kind: KIND_BYTE, status: ST_OK, value_byte: b,
                     char_pos: pos6(emit_len), arg_index: idx5(cnt)};
          res_cnt  = 2'd1;
          len_next = len_inc[LW-1:0];
        end
      end
      if (want_end) begin
        res[0] = '{last: 1'b1, kind: KIND_END, status: ST_OK, value_byte: 8'd0,
                   char_pos: pos6(len), arg_index: idx5(cnt)};
        res_cnt   = 2'd1;
        cnt_next  = cnt + 1'b1;
        len_next  = '0;
        mode_next = MODE_BETWEEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BETWEEN;
      qs   <= 1'b0;
      esc  <= 1'b0;
      cnt  <= '0;
      len  <= '0;
      txt  <= '0;
      err  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      qs   <= qs_next;
      esc  <= esc_next;
      cnt  <= cnt_next;
      len  <= len_next;
      txt  <= txt_next;
      err  <= err_next;
    end
  end

  qat_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .load_cnt (res_cnt),
    .load_res (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {3'b000, m_res.status, m_res.value_byte, m_res.char_pos,
                    m_res.arg_index};
  assign m_tuser = m_res.kind;
  assign m_tlast = m_res.last;

endmodule

// ===== rtl/qat_check.sv =====
// ----------------------------------------------------------------------------
// qat_check
// Port-level checks for the quoted argument tokenizer, bound to the top.
// ----------------------------------------------------------------------------
module qat_check import qat_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // a status word always closes the run of its byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
    else $error("status word without tlast");

  // argument bytes and end marks carry an ok status field
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_BYTE || m_tuser == KIND_END)) |-> m_tdata[20:19] == ST_OK)
    else $error("non-status word with status bits set");

  // argument bytes never carry the terminator value
  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE) |-> m_tdata[18:11] != CH_NUL)
    else $error("argument byte is zero");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output word changed under stall");

endmodule

bind quoted_argument_tokenizer qat_check u_qat_check (.*);

// ===== verif/quoted_argument_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_tb
// Feeds command texts through the tokenizer and compares every output word
// with a cycle-free model of the scanner kept in a scoreboard: short directed
// texts, then random texts mixed with texts shaped to hit each capacity limit,
// with idle cycles on both sides and two long output stalls.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer_tb import qat_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ARGS = 16;
  localparam int unsigned ARG_CAP  = 64;
  localparam int unsigned SRC_CAP  = 256;

  class tokenizer_scoreboard;
    mode_t       mode;
    bit          in_single;
    bit          escaped;
    bit          overflow;
    int unsigned n_args;
    int unsigned arg_len;
    int unsigned text_len;
    res_t        run[$];
    res_t        expected_words[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode      = MODE_BETWEEN;
      in_single = 1'b0;
      escaped   = 1'b0;
      overflow  = 1'b0;
      n_args    = 0;
      arg_len   = 0;
      text_len  = 0;
    endfunction

    function bit blank(logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function void push(kind_t k, int unsigned idx, int unsigned pos, logic [7:0] v,
                       status_t st);
      res_t w;
      w.last       = 1'b0;
      w.kind       = k;
      w.status     = st;
      w.value_byte = v;
      w.char_pos   = pos[5:0];
      w.arg_index  = idx[4:0];
      run.push_back(w);
    endfunction

    // a byte that would fill the argument buffer latches the error instead
    function void take_char(logic [7:0] b);
      if (arg_len + 1 >= ARG_CAP) begin
        overflow = 1'b1;
        return;
      end
      push(KIND_BYTE, n_args, arg_len, b, ST_OK);
      arg_len++;
    endfunction

    function void close_argument();
      push(KIND_END, n_args, arg_len, 8'h00, ST_OK);
      n_args++;
      arg_len = 0;
      mode    = MODE_BETWEEN;
    endfunction

    function void note_text_byte(logic [7:0] b);
      status_t st;
      res_t    w;
      run.delete();
      if (b == CH_NUL) begin
        if (!overflow && mode != MODE_BETWEEN) begin
          // trailing backslash stays literal
          if (escaped) begin
            escaped = 1'b0;
            take_char(CH_BSLASH);
          end
          if (!overflow && mode == MODE_PLAIN) close_argument();
        end
        if (text_len == 0) st = ST_EMPTY;
        else if (overflow) st = ST_CAPACITY;
        else if (mode == MODE_QUOTED || n_args == 0) st = ST_PARSE;
        else st = ST_OK;
        push(KIND_STATUS, n_args, 0, 8'h00, st);
        clear();
      end else begin
        if (text_len < SRC_CAP) text_len++;
        if (text_len >= SRC_CAP) overflow = 1'b1;
        if (!overflow) begin
          if (mode == MODE_BETWEEN) begin
            if (!blank(b)) begin
              if (n_args >= MAX_ARGS) begin
                overflow = 1'b1;
              end else begin
                arg_len = 0;
                escaped = 1'b0;
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                  mode      = MODE_QUOTED;
                  in_single = (b == CH_SQUOTE);
                end else begin
                  mode = MODE_PLAIN;
                  if (b == CH_BSLASH) escaped = 1'b1;
                  else take_char(b);
                end
              end
            end
          end else if (escaped) begin
            escaped = 1'b0;
            take_char(b);
          end else if (mode == MODE_PLAIN) begin
            if (b == CH_BSLASH) escaped = 1'b1;
            else if (blank(b)) close_argument();
            else take_char(b);
          end else begin
            if (b == (in_single ? CH_SQUOTE : CH_DQUOTE)) close_argument();
            else if (b == CH_BSLASH) escaped = 1'b1;
            else take_char(b);
          end
        end
      end
      if (run.size() > 0) begin
        w = run[run.size() - 1];
        w.last = 1'b1;
        run[run.size() - 1] = w;
      end
      foreach (run[i]) expected_words.push_back(run[i]);
    endfunction

    function void match(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_word(logic [23:0] data, logic [1:0] user, logic lst);
      res_t w;
      if (expected_words.size() == 0) begin
        $error("word with nothing expected: tdata %h tuser %0d", data, user);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      match("kind", w.kind, user);
      match("arg_index", w.arg_index, data[4:0]);
      match("char_pos", w.char_pos, data[10:5]);
      match("value_byte", w.value_byte, data[18:11]);
      match("status", w.status, data[20:19]);
      match("tdata fill", 0, data[23:21]);
      match("last_of_run", w.last, lst);
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  tokenizer_scoreboard sb;
  logic [7:0]          text_buf[$];
  logic                steady = 1'b0;
  int unsigned         words_seen = 0;
  int unsigned         hold_left = 0;
  int unsigned         random_bytes = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quoted_argument_tokenizer #(
    .MAX_ARGUMENTS    (MAX_ARGS),
    .ARGUMENT_CAPACITY(ARG_CAP),
    .SOURCE_CAPACITY  (SRC_CAP)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // output side: check each word, stall at random, hold off twice for long
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check_word(m_tdata, m_tuser, m_tlast);
        words_seen++;
        if (words_seen == 40 || words_seen == 400) hold_left = 60;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_text_byte(b);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i]);
    send_byte(CH_NUL);
    text_buf.delete();
  endtask

  function automatic void add_str(string s);
    foreach (s[i]) text_buf.push_back(s[i]);
  endfunction

  function automatic void add_blank();
    int unsigned r;
    r = $urandom_range(5);
    text_buf.push_back(r == 5 ? 8'd32 : 8'(9 + r));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    b = any_byte();
    if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) b = 8'h5F;
    return b;
  endfunction

  function automatic void add_arg(bit may_open);
    int unsigned k;
    int unsigned n;
    logic [7:0]  q;
    logic [7:0]  b;
    k = $urandom_range(2);
    if (k == 0) begin
      n = $urandom_range(1, 8);
      b = word_byte();
      if (b == CH_DQUOTE || b == CH_SQUOTE) b = 8'h61;
      text_buf.push_back(b);
      for (int i = 1; i < n; i++) begin
        if ($urandom_range(7) == 0) begin
          text_buf.push_back(CH_BSLASH);
          text_buf.push_back(any_byte());
        end else begin
          text_buf.push_back(word_byte());
        end
      end
    end else begin
      q = (k == 1) ? CH_DQUOTE : CH_SQUOTE;
      text_buf.push_back(q);
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) == 0) begin
          text_buf.push_back(CH_BSLASH);
          text_buf.push_back(any_byte());
        end else begin
          b = any_byte();
          text_buf.push_back(b == q ? 8'd32 : b);
        end
      end
      if (!(may_open && $urandom_range(9) == 0)) text_buf.push_back(q);
    end
  endfunction

  function automatic void add_random_text();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 8) return;
    if (r < 22) begin
      n = $urandom_range(1, 12);
      repeat (n) text_buf.push_back(any_byte());
      return;
    end
    if ($urandom_range(3) == 0) add_blank();
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      add_arg(i == n - 1 || $urandom_range(4) == 0);
      // sometimes the next argument follows the previous one directly, with no blank
      if (i < n - 1 && $urandom_range(9) != 0) begin
        repeat ($urandom_range(1, 2)) add_blank();
      end
    end
    if ($urandom_range(3) == 0) add_blank();
    if ($urandom_range(11) == 0) text_buf.push_back(CH_BSLASH);
  endfunction

  function automatic void add_long_arg(int unsigned n);
    repeat (n) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
  endfunction

  function automatic void add_many_args(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i != 0) add_blank();
      text_buf.push_back(word_byte() | 8'h40);
    end
  endfunction

  // runs of 19 plain bytes split by blanks, so only the text length matters
  function automatic void add_long_text(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 19) add_blank();
      else if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(128, 255)));
      else text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
  endfunction

  initial begin : stimulus
    int unsigned t;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty text, whitespace only, trailing backslash
    send_text();
    add_str(" \t");
    send_text();
    add_str("a\\");
    send_text();
    // empty quotes, closing quote ending an argument, unterminated quote
    add_str("\"\"x 'b");
    send_text();
    // escaped space, all-ones and lowest byte
    add_str("\\ ");
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h01);
    send_text();
    add_str("'a\"'");
    send_text();

    t = 0;
    while (t < 27 || random_bytes < 280) begin
      steady <= (t >= 20 && t < 26);
      case (t)
        3:  add_long_arg(ARG_CAP - 1);
        6:  add_long_arg(ARG_CAP + 2);
        9:  add_many_args(MAX_ARGS);
        12: add_many_args(MAX_ARGS + 1);
        15: add_long_text(SRC_CAP - 1);
        18: add_long_text(SRC_CAP);
        default: begin
          add_random_text();
          random_bytes += text_buf.size() + 1;
        end
      endcase
      send_text();
      t++;
    end
    s_tvalid <= 1'b0;
    steady   <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[quoted_argument_tokenizer] OK");
    end else begin
      $display("[quoted_argument_tokenizer] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[quoted_argument_tokenizer] ERROR");
    $finish;
  end

endmodule
